// ===== rtl/core/difficulty_retarget_unit_macros.svh =====
// Assertion helpers shared by the retarget RTL.
`ifndef DIFFICULTY_RETARGET_UNIT_MACROS_SVH
`define DIFFICULTY_RETARGET_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define DRT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DRT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/drt_pkg.sv =====
package drt_pkg;

  localparam int TargetW = 256;
  localparam int BitsW   = 32;
  localparam int ProdW   = 57;
  localparam int ElapW   = 34;
  localparam int SideW   = BitsW + 1;
  localparam int DivRadixBits = 4;

  localparam logic [31:0] TimespanRst = 32'd1209600;
  localparam logic [63:0] LimitLoRst  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LimitHiRst  = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [5:0] {
    AddrTimespan   = 6'h00,
    AddrNoRetarget = 6'h08,
    AddrLimit0     = 6'h10,
    AddrLimit1     = 6'h18,
    AddrLimit2     = 6'h20,
    AddrLimit3     = 6'h28
  } drt_addr_e;

endpackage

// ===== rtl/core/drt_divider.sv =====
`include "difficulty_retarget_unit_macros.svh"

module drt_divider #(
  parameter int RadixBits = drt_pkg::DivRadixBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [drt_pkg::TargetW-1:0] dvd_i,
  input  logic [31:0]                 dvs_i,
  input  logic [drt_pkg::SideW-1:0]   side_i,
  output logic                        vld_o,
  output logic [drt_pkg::TargetW-1:0] quo_o,
  output logic [drt_pkg::SideW-1:0]   side_o
);

  localparam int TW   = drt_pkg::TargetW;
  localparam int NStg = TW / RadixBits;

  // Restoring division, RadixBits quotient bits per stage.
  function automatic logic [TW+31:0] div_step(logic [TW-1:0] dq, logic [31:0] rm,
                                              logic [31:0] d);
    logic [32:0] r2;
    logic [TW-1:0] q;
    logic [31:0] r;
    q = dq;
    r = rm;
    for (int k = 0; k < RadixBits; k++) begin
      r2 = {r, q[TW-1]};
      q  = {q[TW-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r2   = r2 - {1'b0, d};
        q[0] = 1'b1;
      end
      r = r2[31:0];
    end
    return {r, q};
  endfunction

  logic [NStg-1:0]                 vld_q;
  logic [TW-1:0]                   dq_q   [NStg];
  logic [31:0]                     rm_q   [NStg];
  logic [drt_pkg::SideW-1:0]       side_q [NStg];

  for (genvar g = 0; g < NStg; g++) begin : g_stg
    logic                      vld_in;
    logic [TW-1:0]             dq_in;
    logic [31:0]               rm_in;
    logic [drt_pkg::SideW-1:0] side_in;
    logic [TW+31:0]            step_d;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign dq_in   = dvd_i;
      assign rm_in   = '0;
      assign side_in = side_i;
    end else begin : g_rest
      assign vld_in  = vld_q[g-1];
      assign dq_in   = dq_q[g-1];
      assign rm_in   = rm_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      step_d = div_step(dq_in, rm_in, dvs_i);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[g]   <= step_d[TW-1:0];
        rm_q[g]   <= step_d[TW+31:TW];
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NStg-1];
  assign quo_o  = dq_q[NStg-1];
  assign side_o = side_q[NStg-1];

  `DRT_ASSERT_IMP(a_rem_below_dvs, vld_q[NStg-1] && (dvs_i != '0), rm_q[NStg-1] < dvs_i, "remainder not below divisor")

endmodule

// ===== rtl/core/difficulty_retarget_unit.sv =====
// Channel   Dir  Fields (low bit first)                        Role
// s_axis    in   tip_bits[31:0] tip_time[63:32] first_time[95:64]  retarget request
// m_axis    out  new_bits[31:0]                                 next compact target
// apb       in   regs at 8*i: timespan, no_retarget, limit 0..3  configuration
//
// Fully pipelined: one request per cycle while m_axis is not stalled; the
// divider retires DivRadixBits quotient bits per stage.
// Reset (rst_ni low, async) clears all valid bits and
// loads the register defaults. Every stage moves only while the output
// register is empty or being taken, so a stall on m_axis freezes the whole
// pipe and back-pressures s_axis in the same cycle.
`include "difficulty_retarget_unit_macros.svh"

module difficulty_retarget_unit #(
  parameter int DivRadixBits = drt_pkg::DivRadixBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // tip_bits, tip_time, first_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // new_bits
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int TW = drt_pkg::TargetW;

  // ---------------- configuration ----------------
  logic [31:0]   ts_q;
  logic          nort_q;
  logic [63:0]   lim_q [4];
  logic [TW-1:0] limit;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign limit  = {lim_q[3], lim_q[2], lim_q[1], lim_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q     <= drt_pkg::TimespanRst;
      nort_q   <= 1'b0;
      lim_q[0] <= drt_pkg::LimitLoRst;
      lim_q[1] <= drt_pkg::LimitLoRst;
      lim_q[2] <= drt_pkg::LimitLoRst;
      lim_q[3] <= drt_pkg::LimitHiRst;
    end else if (wr_en) begin
      unique case (drt_pkg::drt_addr_e'(paddr))
        drt_pkg::AddrTimespan:   ts_q     <= pwdata[31:0];
        drt_pkg::AddrNoRetarget: nort_q   <= pwdata[0];
        drt_pkg::AddrLimit0:     lim_q[0] <= pwdata;
        drt_pkg::AddrLimit1:     lim_q[1] <= pwdata;
        drt_pkg::AddrLimit2:     lim_q[2] <= pwdata;
        drt_pkg::AddrLimit3:     lim_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (drt_pkg::drt_addr_e'(paddr))
      drt_pkg::AddrTimespan:   prdata = {32'd0, ts_q};
      drt_pkg::AddrNoRetarget: prdata = {63'd0, nort_q};
      drt_pkg::AddrLimit0:     prdata = lim_q[0];
      drt_pkg::AddrLimit1:     prdata = lim_q[1];
      drt_pkg::AddrLimit2:     prdata = lim_q[2];
      drt_pkg::AddrLimit3:     prdata = lim_q[3];
      default:                 prdata = '0;
    endcase
  end

  // ---------------- global advance ----------------
  logic out_vld_q;
  logic adv;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 1: clamp time, expand mantissa ----------------
  logic [31:0] in_bits, in_tip, in_first;
  assign in_bits  = s_axis_tdata[31:0];
  assign in_tip   = s_axis_tdata[63:32];
  assign in_first = s_axis_tdata[95:64];

  logic signed [34:0] diff, quarter, fourfold, elap;
  logic [7:0]  expo, sb;
  logic [22:0] man_d;
  logic [4:0]  shb_d;

  always_comb begin
    diff     = $signed({3'b000, in_tip}) - $signed({3'b000, in_first});
    quarter  = $signed({5'd0, ts_q[31:2]});
    fourfold = $signed({1'b0, ts_q, 2'b00});
    elap     = (diff < quarter) ? quarter : diff;
    elap     = (elap > fourfold) ? fourfold : elap;

    expo  = in_bits[31:24];
    sb    = expo - 8'd3;
    man_d = in_bits[22:0];
    shb_d = '0;
    if (expo <= 8'd3) begin
      man_d = in_bits[22:0] >> {(2'd3 - expo[1:0]), 3'b000};
    end else if (sb >= 8'd32) begin
      man_d = '0;       // shifted entirely past the top
    end else begin
      shb_d = sb[4:0];
    end
  end

  logic                            s1_vld_q;
  logic [drt_pkg::ElapW-1:0]       s1_elap_q;
  logic [22:0]                     s1_man_q;
  logic [4:0]                      s1_shb_q;
  logic [drt_pkg::SideW-1:0]       s1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_elap_q <= elap[drt_pkg::ElapW-1:0];
      s1_man_q  <= man_d;
      s1_shb_q  <= shb_d;
      s1_side_q <= {nort_q, in_bits};
    end
  end

  // ---------------- stage 2: mantissa times elapsed ----------------
  logic                        s2_vld_q;
  logic [drt_pkg::ProdW-1:0]   s2_prod_q;
  logic [4:0]                  s2_shb_q;
  logic [drt_pkg::SideW-1:0]   s2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_prod_q <= {{(drt_pkg::ProdW-23){1'b0}}, s1_man_q} * s1_elap_q;
      s2_shb_q  <= s1_shb_q;
      s2_side_q <= s1_side_q;
    end
  end

  // ---------------- stage 3: byte shift into 256 bits (mod 2^256) ----------------
  logic                        s3_vld_q;
  logic [TW-1:0]               s3_dvd_q;
  logic [drt_pkg::SideW-1:0]   s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (adv) s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dvd_q  <= {{(TW-drt_pkg::ProdW){1'b0}}, s2_prod_q} << {s2_shb_q, 3'b000};
      s3_side_q <= s2_side_q;
    end
  end

  // ---------------- divider ----------------
  logic                        dv_vld;
  logic [TW-1:0]               dv_quo;
  logic [drt_pkg::SideW-1:0]   dv_side;

  drt_divider #(
    .RadixBits (DivRadixBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s3_vld_q),
    .dvd_i  (s3_dvd_q),
    .dvs_i  (ts_q),
    .side_i (s3_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // ---------------- cap at limit ----------------
  logic [TW-1:0]               quo_fix;
  logic                        cap_vld_q;
  logic [TW-1:0]               cap_t_q;
  logic [drt_pkg::SideW-1:0]   cap_side_q;

  assign quo_fix = (ts_q == '0) ? {TW{1'b1}} : dv_quo;   // zero timespan saturates

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_vld_q <= 1'b0;
    else if (adv) cap_vld_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cap_t_q    <= (quo_fix > limit) ? limit : quo_fix;
      cap_side_q <= dv_side;
    end
  end

  // ---------------- encode, part 1: byte size ----------------
  logic [5:0] size_d;
  always_comb begin
    size_d = '0;
    for (int i = 0; i < TW / 8; i++) begin
      if (cap_t_q[8*i +: 8] != 8'd0) size_d = 6'(i + 1);
    end
  end

  logic                        e1_vld_q;
  logic [TW-1:0]               e1_t_q;
  logic [5:0]                  e1_size_q;
  logic [drt_pkg::SideW-1:0]   e1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e1_vld_q <= 1'b0;
    else if (adv) e1_vld_q <= cap_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_t_q    <= cap_t_q;
      e1_size_q <= size_d;
      e1_side_q <= cap_side_q;
    end
  end

  // ---------------- encode, part 2: mantissa pick, output register ----------------
  logic [23:0] man_e;
  logic [5:0]  sz_e;
  logic [31:0] enc_d;

  always_comb begin
    sz_e = e1_size_q;
    if (e1_size_q <= 6'd3) begin
      man_e = e1_t_q[23:0] << {(2'd3 - e1_size_q[1:0]), 3'b000};
    end else begin
      man_e = 24'(e1_t_q >> {(e1_size_q - 6'd3), 3'b000});
    end
    if (man_e[23]) begin          // keep the sign bit clear
      man_e = man_e >> 8;
      sz_e  = e1_size_q + 6'd1;
    end
    enc_d = {2'b00, sz_e, man_e};
  end

  logic [31:0] out_bits_q;
  logic        out_byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= e1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byp_q  <= e1_side_q[drt_pkg::BitsW];
      out_bits_q <= e1_side_q[drt_pkg::BitsW] ? e1_side_q[drt_pkg::BitsW-1:0] : enc_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_bits_q;

  `DRT_ASSERT_IMP(a_cap_le_limit, cap_vld_q, cap_t_q <= limit, "capped target above limit")
  `DRT_ASSERT_IMP(a_no_sign_bit, out_vld_q && !out_byp_q, !out_bits_q[23], "sign bit set in result")
  `DRT_ASSERT_NXT(a_stall_freezes, !adv, $stable(cap_vld_q) && $stable(e1_vld_q), "pipe moved in stall")

endmodule

// ===== bench/tb_difficulty_retarget_unit.sv =====
`timescale 1ns / 1ps

module tb_difficulty_retarget_unit;

  // Expected new_bits words, oldest first; checks arrive in request order.
  class retarget_scoreboard;
    logic [31:0] pending_bits[$];
    int          n_errors;
    int          n_checked;

    function void note_request(logic [31:0] new_bits);
      pending_bits.push_back(new_bits);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_bits.size() == 0) begin
        $error("new_bits: no request waiting, actual %h", got);
        n_errors++;
        return;
      end
      want = pending_bits.pop_front();
      n_checked++;
      if (got !== want) begin
        $error("new_bits: expected %h actual %h", want, got);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // tip_bits[31:0], tip_time[63:32], first_time[95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // new_bits[31:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  difficulty_retarget_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  retarget_scoreboard sb = new();

  // Local copy of the register file, tracked as it is written.
  logic [31:0]  timespan_q;
  logic         no_retarget_q;
  logic [255:0] pow_limit_q;

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int n_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Expand the compact word, scale by clamped elapsed time over timespan, cap, re-encode; bypass returns tip_bits.
  function automatic logic [31:0] next_required_bits(logic [31:0] tip_bits,
                                                     logic [31:0] tip_time,
                                                     logic [31:0] first_time);
    longint       elapsed;
    longint       quarter;
    longint       fourfold;
    logic [7:0]   expo;
    logic [22:0]  mant;
    logic [255:0] tgt;
    logic [31:0]  cm;
    int           bitlen;
    int           nbytes;
    if (no_retarget_q) return tip_bits;
    quarter  = longint'(timespan_q / 4);
    fourfold = longint'(timespan_q) * 4;
    // signed difference: a tip older than the period start clamps up
    elapsed  = longint'(tip_time) - longint'(first_time);
    if (elapsed < quarter) elapsed = quarter;
    if (elapsed > fourfold) elapsed = fourfold;
    expo = tip_bits[31:24];
    mant = tip_bits[22:0];   // sign bit dropped
    if (expo <= 3) tgt = 256'(mant) >> (8 * (3 - expo));
    else tgt = 256'(mant) << (8 * (int'(expo) - 3));   // bits past 255 lost
    tgt = tgt * 256'(elapsed);
    if (timespan_q != 0) tgt = tgt / 256'(timespan_q);
    else tgt = '1;
    if (tgt > pow_limit_q) tgt = pow_limit_q;
    bitlen = 0;
    for (int b = 255; b >= 0; b--) begin
      if (tgt[b] && bitlen == 0) bitlen = b + 1;
    end
    nbytes = (bitlen + 7) / 8;
    if (nbytes <= 3) cm = tgt[31:0] << (8 * (3 - nbytes));
    else cm = 32'(tgt >> (8 * (nbytes - 3)));
    cm &= 32'h00FF_FFFF;
    if (cm[23]) begin
      cm = cm >> 8;
      nbytes++;
    end
    return cm | (32'(nbytes) << 24);
  endfunction

  // APB write: setup then access; register takes the value on the access edge.
  task automatic reg_write(drt_pkg::drt_addr_e addr, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      drt_pkg::AddrTimespan:   timespan_q           = value[31:0];
      drt_pkg::AddrNoRetarget: no_retarget_q        = value[0];
      drt_pkg::AddrLimit0:     pow_limit_q[63:0]    = value;
      drt_pkg::AddrLimit1:     pow_limit_q[127:64]  = value;
      drt_pkg::AddrLimit2:     pow_limit_q[191:128] = value;
      drt_pkg::AddrLimit3:     pow_limit_q[255:192] = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] ts, logic nr, logic [255:0] lim);
    reg_write(drt_pkg::AddrTimespan, 64'(ts));
    reg_write(drt_pkg::AddrNoRetarget, 64'(nr));
    reg_write(drt_pkg::AddrLimit0, lim[63:0]);
    reg_write(drt_pkg::AddrLimit1, lim[127:64]);
    reg_write(drt_pkg::AddrLimit2, lim[191:128]);
    reg_write(drt_pkg::AddrLimit3, lim[255:192]);
  endtask

  // Offer one request, hold until accepted, then maybe drop valid and idle.
  task automatic send_request(logic [31:0] tip_bits, logic [31:0] tip_time,
                              logic [31:0] first_time);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {first_time, tip_time, tip_bits};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(next_required_bits(tip_bits, tip_time, first_time));
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Wait for every pending result, then give margin before touching registers.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_bits.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Mostly well-formed retargets: sane exponent, times around the timespan.
  task automatic send_random();
    logic [31:0] bits;
    logic [31:0] first;
    longint      span;
    bits  = $urandom();
    first = $urandom();
    case ($urandom_range(9))
      0: ;  // exponent left as raw noise
      1, 2: bits[31:24] = 8'($urandom_range(0, 40));
      default: bits[31:24] = 8'($urandom_range(3, 32));
    endcase
    if ($urandom_range(9) == 0) begin
      send_request(bits, $urandom(), first);
    end else begin
      span = longint'(timespan_q) * 5 + 1;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      send_request(bits, first + 32'($urandom_range(0, 32'(span))), first);
    end
  endtask

  // Receiver: random stalls, plus a long hold counted here on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    #2_000_000;
    $display("tb_difficulty_retarget_unit: errors");
    $finish;
  end

  initial begin
    logic [31:0]  spans[6];
    logic [255:0] lims[6];
    logic [31:0]  t0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_idle_pct    = 28;
    recv_idle_pct    = 78;
    recv_hold_cycles = 0;
    n_sent           = 0;
    timespan_q       = drt_pkg::TimespanRst;
    no_retarget_q    = 1'b0;
    pow_limit_q      = {drt_pkg::LimitHiRst, drt_pkg::LimitLoRst, drt_pkg::LimitLoRst,
                        drt_pkg::LimitLoRst};
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed requests under reset defaults.
    t0 = 32'd1_000_000_000;
    send_request(32'h1D00_FFFF, t0 + 32'd1209600, t0);   // on schedule
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 32'h0);    // zero target
    send_request(32'h01FF_FFFF, t0 + 32'd600, t0);       // small exponents
    send_request(32'h0212_3456, t0, t0);
    send_request(32'h037F_FFFF, t0, t0 + 32'd5);          // negative elapsed
    send_request(32'h04FF_FFFF, 32'h0, 32'hFFFF_FFFF);    // sign bit set
    send_request(32'h2200_FFFF, t0 + 32'd100, t0);
    send_request(32'h2212_3456, t0 + 32'd9_000_000, t0);  // expansion overflow
    send_request(32'h2312_3456, t0, t0);                  // expands to zero
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(32'h207F_FFFF, 32'hFFFF_FFFF, 32'h0);    // capped at limit
    send_request(32'h1C80_0000, t0 + 32'd302400, t0);     // exactly a quarter
    send_request(32'h1B7F_FFFF, t0 + 32'd4838400, t0);    // exactly fourfold
    send_request(32'h1755_AA55, 32'hAAAA_AAAA, 32'h5555_5555);
    drain_pipe();

    // Settings: tiny, huge and zero timespan, odd limits, bypass.
    spans[0] = 32'd1;           lims[0] = '1;
    spans[1] = 32'hFFFF_FFFF;   lims[1] = {64'h0, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    spans[2] = 32'd0;           lims[2] = {64'h1234_5678_9ABC_DEF0, 192'h0};
    spans[3] = 32'd600;         lims[3] = '0;
    spans[4] = 32'd1209600;     lims[4] = {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
    spans[5] = 32'd2016;        lims[5] = {$urandom(), $urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom(), $urandom(), $urandom()};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 78;
        recv_idle_pct = 28;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph < 6) set_config(spans[ph], 1'b0, lims[ph]);
      else set_config(32'd1209600, 1'b1, '1);   // bypass: tip bits pass through
      for (int k = 0; k < 220; k++) begin
        // long receiver hold while the sender keeps offering: pipe fills up
        if (ph == 4 && k == 10) recv_hold_cycles = 400;
        send_random();
      end
      drain_pipe();   // sender pauses until every result is back
    end

    $display("Covered %0d retarget requests, %0d results checked,", n_sent, sb.n_checked);
    $display("over 8 register settings incl. zero timespan, bypass and backpressure.");
    if (sb.n_errors == 0) begin
      $display("tb_difficulty_retarget_unit: clean");
    end else begin
      $display("tb_difficulty_retarget_unit: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/drt_pkg.sv
rtl/core/drt_divider.sv
rtl/core/difficulty_retarget_unit.sv
bench/tb_difficulty_retarget_unit.sv
